/* sv/iir_tdf2_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package iir_tdf2_pkg;

  localparam int ORDER     = 2;
  localparam int CHANNELS  = 2;

  localparam int X_W       = 16;
  localparam int COEF_W    = 32;
  localparam int PROD_W    = COEF_W + X_W;
  localparam int ST_W      = 48;
  localparam int ACC_W     = ST_W + 2;
  localparam int FRAC_BITS = 28;
  localparam int DEPTH     = ORDER * CHANNELS;
  localparam int ADDR_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int STG_W     = (ORDER > 1) ? $clog2(ORDER) : 1;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_B0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_B1 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_B2 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_A1 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_A2 = 3'd4;

  localparam logic [COEF_W-1:0] B0_RESET = 32'h1000_0000;

  localparam logic [3:0] OP_NONE    = 4'd0;
  localparam logic [3:0] OP_CAPTURE = 4'd1;
  localparam logic [3:0] OP_Y0      = 4'd2;
  localparam logic [3:0] OP_Y1      = 4'd3;
  localparam logic [3:0] OP_Y2      = 4'd4;
  localparam logic [3:0] OP_ZB      = 4'd5;
  localparam logic [3:0] OP_ZA      = 4'd6;
  localparam logic [3:0] OP_ZS      = 4'd7;
  localparam logic [3:0] OP_OUT     = 4'd8;

  typedef struct packed {
    logic signed [X_W-1:0] sample_in;
    logic                  channel;
  } in_t;

  typedef struct packed {
    logic signed [X_W-1:0] sample_out;
    logic                  channel_out;
    logic                  clipped;
  } out_t;

  typedef struct packed {
    logic [3:0]       op;
    logic [STG_W-1:0] stage;
  } dp_cmd_t;

  typedef struct packed {
    logic chan_bad;
  } dp_sts_t;

endpackage

`default_nettype wire

/* sv/iir_tdf2_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none

module iir_tdf2_ctrl (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   in_valid,
  output logic                  in_stall,
  output logic                  out_valid,
  input  wire                   out_stall,
  input  iir_tdf2_pkg::dp_sts_t sts,
  output iir_tdf2_pkg::dp_cmd_t cmd
);
  import iir_tdf2_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_Y0   = 3'd1;
  localparam logic [2:0] S_Y1   = 3'd2;
  localparam logic [2:0] S_Y2   = 3'd3;
  localparam logic [2:0] S_ZB   = 3'd4;
  localparam logic [2:0] S_ZA   = 3'd5;
  localparam logic [2:0] S_ZS   = 3'd6;
  localparam logic [2:0] S_DONE = 3'd7;

  logic [2:0]       state_r, state_nxt;
  logic [STG_W-1:0] stage_r, stage_nxt;
  logic             out_valid_r, out_valid_nxt;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    stage_nxt     = stage_r;
    out_valid_nxt = out_valid_r & out_stall;
    cmd.op        = OP_NONE;
    cmd.stage     = stage_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op    = OP_CAPTURE;
          state_nxt = sts.chan_bad ? S_DONE : S_Y0;
        end
      end
      S_Y0: begin
        cmd.op    = OP_Y0;
        state_nxt = S_Y1;
      end
      S_Y1: begin
        cmd.op    = OP_Y1;
        state_nxt = S_Y2;
      end
      S_Y2: begin
        cmd.op    = OP_Y2;
        stage_nxt = '0;
        state_nxt = S_ZB;
      end
      S_ZB: begin
        cmd.op    = OP_ZB;
        state_nxt = S_ZA;
      end
      S_ZA: begin
        cmd.op    = OP_ZA;
        state_nxt = S_ZS;
      end
      S_ZS: begin
        cmd.op = OP_ZS;
        if (stage_r == STG_W'(ORDER - 1)) begin
          state_nxt = S_DONE;
        end else begin
          stage_nxt = stage_r + 1'b1;
          state_nxt = S_ZB;
        end
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          cmd.op        = OP_OUT;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      stage_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      stage_r     <= stage_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

/* sv/iir_tdf2_dp.sv */
`timescale 1ns / 1ps
`default_nettype none

module iir_tdf2_dp (
  input  wire                                    clk,
  input  wire                                    rst_n,
  input  iir_tdf2_pkg::dp_cmd_t                  cmd,
  output iir_tdf2_pkg::dp_sts_t                  sts,
  input  iir_tdf2_pkg::in_t                      in_data,
  output iir_tdf2_pkg::out_t                     out_data,
  input  wire                                    cfg_we,
  input  wire [iir_tdf2_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire [iir_tdf2_pkg::COEF_W-1:0]         cfg_data
);
  import iir_tdf2_pkg::*;

  localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(64'd1 << (FRAC_BITS - 1));

  logic signed [COEF_W-1:0] b0_r, b1_r, b2_r, a1_r, a2_r;
  logic signed [X_W-1:0]    x_r;
  logic                     c_r;
  logic signed [X_W-1:0]    y_r;
  logic                     clip_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [ST_W-1:0]   rdata_r;
  logic signed [ACC_W-1:0]  acc_r;
  out_t                     out_r;

  logic signed [ST_W-1:0]   mem [DEPTH];
  logic [DEPTH-1:0]         vld_r;

  logic signed [COEF_W-1:0] mul_a;
  logic signed [X_W-1:0]    mul_b;
  logic signed [PROD_W-1:0] prod_nxt;
  logic [ADDR_W-1:0]        rd_addr, wr_addr;
  logic                     rd_en;
  logic signed [ACC_W-1:0]  z_sum;
  logic signed [ST_W-1:0]   z_sat;
  logic signed [ACC_W-FRAC_BITS-1:0] y_full;
  logic                     y_ovf;

  function automatic logic [ADDR_W-1:0] mem_addr(input int stg, input logic ch);
    return ADDR_W'(stg * CHANNELS + int'(ch));
  endfunction

  assign sts.chan_bad = (int'(in_data.channel) >= CHANNELS);
  assign out_data     = out_r;

  always_comb begin
    mul_a = '0;
    mul_b = x_r;
    case (cmd.op)
      OP_Y0: mul_a = b0_r;
      OP_ZB: begin
        case (int'(cmd.stage) + 1)
          1:       mul_a = b1_r;
          2:       mul_a = b2_r;
          default: mul_a = '0;
        endcase
      end
      OP_ZA: begin
        mul_b = y_r;
        case (int'(cmd.stage) + 1)
          1:       mul_a = a1_r;
          2:       mul_a = a2_r;
          default: mul_a = '0;
        endcase
      end
      default: mul_a = '0;
    endcase
    prod_nxt = $signed(PROD_W'(mul_a)) * $signed(PROD_W'(mul_b));
  end

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = mem_addr(0, c_r);
    if (cmd.op == OP_Y0) begin
      rd_en = 1'b1;
    end else if (cmd.op == OP_ZB && (int'(cmd.stage) + 1) < ORDER) begin
      rd_en   = 1'b1;
      rd_addr = mem_addr(int'(cmd.stage) + 1, c_r);
    end
    wr_addr = mem_addr(int'(cmd.stage), c_r);
  end

  assign z_sum = acc_r - ACC_W'(prod_r);
  always_comb begin
    if (z_sum[ACC_W-1:ST_W-1] == '0 || z_sum[ACC_W-1:ST_W-1] == '1) begin
      z_sat = z_sum[ST_W-1:0];
    end else if (z_sum[ACC_W-1]) begin
      z_sat = {1'b1, {(ST_W-1){1'b0}}};
    end else begin
      z_sat = {1'b0, {(ST_W-1){1'b1}}};
    end
  end

  assign y_full = acc_r[ACC_W-1:FRAC_BITS];
  assign y_ovf  = !(y_full[ACC_W-FRAC_BITS-1:X_W-1] == '0 ||
                    y_full[ACC_W-FRAC_BITS-1:X_W-1] == '1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b0_r <= B0_RESET;
      b1_r <= '0;
      b2_r <= '0;
      a1_r <= '0;
      a2_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_B0:  b0_r <= cfg_data;
        REG_B1:  b1_r <= cfg_data;
        REG_B2:  b2_r <= cfg_data;
        REG_A1:  a1_r <= cfg_data;
        REG_A2:  a2_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (cmd.op == OP_ZS) begin
      vld_r[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_ZS) begin
      mem[wr_addr] <= z_sat;
    end
    if (rd_en && vld_r[rd_addr]) begin
      rdata_r <= mem[rd_addr];
    end else if (cmd.op == OP_Y0 || cmd.op == OP_ZB) begin
      rdata_r <= '0;
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_CAPTURE: begin
        x_r    <= in_data.sample_in;
        c_r    <= in_data.channel;
        y_r    <= '0;
        clip_r <= 1'b0;
      end
      OP_Y0: prod_r <= prod_nxt;
      OP_Y1: acc_r  <= ACC_W'(prod_r) + ACC_W'(rdata_r) + ROUND_HALF;
      OP_Y2: begin
        clip_r <= y_ovf;
        if (!y_ovf) begin
          y_r <= y_full[X_W-1:0];
        end else if (y_full[ACC_W-FRAC_BITS-1]) begin
          y_r <= {1'b1, {(X_W-1){1'b0}}};
        end else begin
          y_r <= {1'b0, {(X_W-1){1'b1}}};
        end
      end
      OP_ZB: prod_r <= prod_nxt;
      OP_ZA: begin
        acc_r  <= ACC_W'(prod_r) + ACC_W'(rdata_r);
        prod_r <= prod_nxt;
      end
      OP_OUT: begin
        out_r.sample_out  <= y_r;
        out_r.channel_out <= c_r;
        out_r.clipped     <= clip_r;
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

/* sv/iir_filter_transposed_df2.sv */
// Two-channel second-order IIR filter in transposed direct form II.
// The input channel takes one word per sample: a signed 16-bit sample and its
// channel number. It is accepted at a clock edge with in_valid high and
// in_stall low. Each word yields exactly one result word on the output channel:
// the rounded, saturated 16-bit sample, its channel and a clipped flag.
// Coefficients b0, b1, b2, a1, a2 are signed Q3.28 values written through the
// cfg_ port at indexes 0 to 4; cfg_ready is always high and writes belong in
// idle periods.
// One multiplier is shared by all five products, stepped by a small sequencer.
// A sample passes through a capture step, the Y0, Y1 and Y2 steps, the ZB, ZA
// and ZS steps once per stage and a final output step; the next sample is
// accepted in the cycle after the result is registered.
// When the receiver stalls, the result holds in the output register while the
// filter still accepts and processes one more sample; that sample then waits
// until the register frees up.
// A synchronous reset restores the default coefficients (a pass-through
// filter), clears the delay state of every channel and drops out_valid.
`timescale 1ns / 1ps
`default_nettype none

module iir_filter_transposed_df2 (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire                                in_valid,
  output logic                               in_stall,
  input  iir_tdf2_pkg::in_t                  in_data,
  output logic                               out_valid,
  input  wire                                out_stall,
  output iir_tdf2_pkg::out_t                 out_data,
  input  wire                                cfg_valid,
  output logic                               cfg_ready,
  input  wire [iir_tdf2_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire [iir_tdf2_pkg::COEF_W-1:0]     cfg_data
);
  import iir_tdf2_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  assign cfg_ready = 1'b1;

  iir_tdf2_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  iir_tdf2_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (in_data),
    .out_data  (out_data),
    .cfg_we    (cfg_valid & cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

endmodule

`default_nettype wire

/* sv/iir_tdf2_chk.sv */
`timescale 1ns / 1ps
`default_nettype none

module iir_tdf2_chk (
  input wire                                clk,
  input wire                                rst_n,
  input wire                                in_valid,
  input wire                                in_stall,
  input wire                                out_valid,
  input wire                                out_stall,
  input iir_tdf2_pkg::out_t                 out_data
);
  import iir_tdf2_pkg::*;

  logic in_acc;
  assign in_acc = in_valid && !in_stall;

  // The filter works on one sample at a time.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> in_stall)
    else $error("input accepted while a sample is in progress");

  // A clipped result sits on one of the two rails.
  a_clip_at_rail: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.clipped |->
      out_data.sample_out == 16'sh7FFF || out_data.sample_out == 16'sh8000)
    else $error("clipped flag set on a sample that is not at a rail");

  // Reset leaves the block empty and ready.
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("block not idle after reset");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result word changed or dropped");

endmodule

bind iir_filter_transposed_df2 iir_tdf2_chk u_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire
